[rtl/core/tppe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tppe_pkg;

  typedef enum logic [2:0] {
    REQ_EJECT   = 3'd0,
    REQ_APPEND  = 3'd1,
    REQ_PLAY    = 3'd2,
    REQ_STOP    = 3'd3,
    REQ_REWIND  = 3'd4,
    REQ_PAUSE   = 3'd5,
    REQ_ADVANCE = 3'd6,
    REQ_READ    = 3'd7
  } req_e;

  localparam logic [1:0] CFG_INITIAL_LEVEL = 2'd0;
  localparam logic [1:0] CFG_REWIND_SPEED  = 2'd1;
  localparam logic [1:0] CFG_LEADER_GAP    = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] duration;
    logic [15:0] cycle_count;
    logic        pause_value;
  } req_t;

  typedef struct packed {
    logic        tape_level;
    logic        playing;
    logic        armed;
    logic        rewind_busy;
    logic [14:0] position;
    logic        store_full;
  } rsp_t;

endpackage
`default_nettype wire

[rtl/core/tape_pulse_playback_engine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A control request passes through the execute state and then holds its response
// valid until it is taken.
// Advance requests walk each pulse while playing through an index step, memory address,
// memory data and the shared subtract/compare, and while rewinding through the last three.
// One request is handled at a time; the next is accepted the cycle after the response is taken.
// Reset (rst_ni, asynchronous, active low) clears all control state; the duration
// memory holds no reset value and only entries below the tape length are read.
module tape_pulse_playback_engine_unit #(
  parameter int TAPE_DEPTH = 16384
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               req_valid_i,
  output logic              req_ready_o,
  input  wire tppe_pkg::req_t req_i,
  output logic              rsp_valid_o,
  input  wire               rsp_ready_i,
  output tppe_pkg::rsp_t    rsp_o,
  input  wire               cfg_we_i,
  input  wire [1:0]         cfg_index_i,
  input  wire [23:0]        cfg_data_i
);
  import tppe_pkg::*;

  localparam int AW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int LW = $clog2(TAPE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FETCH, S_WAIT, S_STEP, S_DONE
  } state_e;

  // Configuration registers.
  logic        init_lvl_q;
  logic [7:0]  rw_speed_q;
  logic [23:0] gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_lvl_q <= 1'b0;
      rw_speed_q <= 8'd8;
      gap_q      <= 24'd511363;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INITIAL_LEVEL: init_lvl_q <= cfg_data_i[0];
        CFG_REWIND_SPEED:  rw_speed_q <= cfg_data_i[7:0];
        CFG_LEADER_GAP:    gap_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Duration memory: one write port for appends, one registered read port.
  logic [31:0] mem [TAPE_DEPTH];
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= mem[mem_raddr];
  end

  state_e      state_q;
  state_e      exec_next;
  req_t        req_q;
  logic [LW-1:0] len_q, idx_q;
  logic [31:0] ctt_q;
  logic        lvl_q, act_q, arm_q, rw_q, pause_q, full_q;
  logic [31:0] carry_q;
  logic [47:0] clk_cnt_q, last_rd_q;
  // Remaining budget: advance cycles while playing, speed*cycles+carry while rewinding.
  logic [39:0] bud_q;
  logic [23:0] rw_prod;

  logic [47:0] since_rd;
  assign since_rd = clk_cnt_q - last_rd_q;

  assign rw_prod = 24'(req_q.cycle_count) * 24'(rw_speed_q);

  // Shared step unit: compare budget against the current segment and subtract.
  logic [39:0] seg;
  logic [39:0] diff;
  logic        fits;
  always_comb begin
    if (rw_q) seg = {8'd0, mem_rdata_q};
    else      seg = {8'd0, ctt_q};
    diff = bud_q - seg;
    fits = (bud_q >= seg);
  end

  logic [LW-1:0] idx_m1;
  assign idx_m1 = idx_q - LW'(1);

  // Where the execute cycle goes next: an advance that moves the tape walks pulses.
  always_comb begin
    exec_next = S_DONE;
    if (req_q.req_type == REQ_ADVANCE && req_q.cycle_count != 16'd0 && !pause_q) begin
      if (rw_q) begin
        if (len_q != '0 && idx_q != '0) exec_next = S_FETCH;
      end else if (act_q && len_q != '0) begin
        exec_next = S_STEP;
      end
    end
  end

  assign mem_we    = (state_q == S_EXEC) && (req_q.req_type == REQ_APPEND) &&
                     (len_q < LW'(TAPE_DEPTH));
  assign mem_waddr = len_q[AW-1:0];
  assign mem_wdata = (req_q.duration == 32'd0) ? 32'd1 : req_q.duration;
  // Both walks read the entry just below the index: playback after it has stepped
  // forward, rewind before it steps back.
  assign mem_raddr = idx_m1[AW-1:0];

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_DONE);
  assign rsp_o = '{tape_level: lvl_q, playing: act_q, armed: arm_q, rewind_busy: rw_q,
                   position: 15'(idx_q), store_full: full_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= '0;
      len_q     <= '0;
      idx_q     <= '0;
      ctt_q     <= '0;
      lvl_q     <= 1'b0;
      act_q     <= 1'b0;
      arm_q     <= 1'b0;
      rw_q      <= 1'b0;
      pause_q   <= 1'b0;
      full_q    <= 1'b0;
      carry_q   <= '0;
      clk_cnt_q <= '0;
      last_rd_q <= '0;
      bud_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q   <= req_i;
            full_q  <= 1'b0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= exec_next;
          unique case (req_q.req_type)
            REQ_EJECT: begin
              len_q <= '0; arm_q <= 1'b0; act_q <= 1'b0; idx_q <= '0; ctt_q <= '0;
              lvl_q <= 1'b0; rw_q <= 1'b0; carry_q <= '0; last_rd_q <= clk_cnt_q;
            end
            REQ_APPEND: begin
              if (len_q >= LW'(TAPE_DEPTH)) full_q <= 1'b1;
              else len_q <= len_q + LW'(1);
            end
            REQ_PLAY: begin
              if (len_q != '0) begin
                pause_q <= 1'b0; arm_q <= 1'b1; act_q <= 1'b0; idx_q <= '0;
                ctt_q <= '0; lvl_q <= init_lvl_q; rw_q <= 1'b0; carry_q <= '0;
                last_rd_q <= clk_cnt_q;
              end
            end
            REQ_STOP: begin
              act_q <= 1'b0; arm_q <= 1'b0; rw_q <= 1'b0; carry_q <= '0; ctt_q <= '0;
            end
            REQ_REWIND: begin
              if (len_q == '0 || idx_q == '0) begin
                arm_q <= 1'b0; act_q <= 1'b0; idx_q <= '0; ctt_q <= '0;
                lvl_q <= init_lvl_q; rw_q <= 1'b0; carry_q <= '0;
                last_rd_q <= clk_cnt_q;
              end else begin
                rw_q <= 1'b1; carry_q <= '0; act_q <= 1'b0; arm_q <= 1'b0;
              end
            end
            REQ_PAUSE: pause_q <= req_q.pause_value;
            REQ_ADVANCE: begin
              if (req_q.cycle_count != 16'd0) begin
                clk_cnt_q <= clk_cnt_q + 48'(req_q.cycle_count);
                if (!pause_q) begin
                  if (rw_q) begin
                    if (len_q == '0 || idx_q == '0) begin
                      arm_q <= 1'b0; act_q <= 1'b0; idx_q <= '0; ctt_q <= '0;
                      lvl_q <= init_lvl_q; rw_q <= 1'b0; carry_q <= '0;
                      last_rd_q <= clk_cnt_q;
                    end else begin
                      bud_q <= 40'(rw_prod) + 40'(carry_q);
                    end
                  end else if (act_q && len_q != '0) begin
                    bud_q <= 40'(req_q.cycle_count);
                  end
                end
              end
            end
            default: begin
              if (!rw_q) begin
                if (arm_q || (len_q != '0 && idx_q != '0 && since_rd > 48'(gap_q))) begin
                  idx_q <= '0; ctt_q <= '0; lvl_q <= init_lvl_q;
                  act_q <= (len_q != '0); arm_q <= 1'b0;
                end
                last_rd_q <= clk_cnt_q;
              end
            end
          endcase
        end
        S_FETCH: state_q <= S_WAIT;
        S_WAIT: begin
          // Memory data is now valid for the addressed segment.
          if (!rw_q) ctt_q <= mem_rdata_q;
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (rw_q) begin
            if (!fits) begin
              carry_q <= 32'(bud_q);
              state_q <= S_DONE;
            end else begin
              bud_q <= diff;
              if (idx_m1 == '0) begin
                // Reached the tape start: restart the deck.
                arm_q <= 1'b0; act_q <= 1'b0; idx_q <= '0; ctt_q <= '0;
                lvl_q <= init_lvl_q; rw_q <= 1'b0; carry_q <= '0;
                last_rd_q <= clk_cnt_q - 48'(req_q.cycle_count);
                state_q <= S_DONE;
              end else begin
                lvl_q   <= ~lvl_q;
                idx_q   <= idx_m1;
                state_q <= S_FETCH;
              end
            end
          end else if (bud_q == '0 || !act_q) begin
            state_q <= S_DONE;
          end else if (ctt_q == '0) begin
            if (idx_q >= len_q) begin
              act_q   <= 1'b0;
              state_q <= S_DONE;
            end else begin
              idx_q   <= idx_q + LW'(1);
              state_q <= S_FETCH;
            end
          end else if (!fits) begin
            ctt_q   <= ctt_q - 32'(bud_q);
            state_q <= S_DONE;
          end else begin
            bud_q <= diff;
            ctt_q <= '0;
            lvl_q <= ~lvl_q;
            if (idx_q >= len_q) act_q <= 1'b0;
          end
        end
        S_DONE: if (rsp_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/sv/tppe_checker.sv]
`timescale 1ns / 1ps
module tppe_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               req_valid_i,
  input  wire               req_ready_i,
  input  tppe_pkg::req_t    req_i,
  input  wire               rsp_valid_i,
  input  wire               rsp_ready_i,
  input  tppe_pkg::rsp_t    rsp_i,
  input  wire               cfg_we_i,
  input  wire [1:0]         cfg_index_i,
  input  wire [23:0]        cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import tppe_pkg::*;

  localparam int unsigned DEPTH = 16384;
  localparam longint unsigned CLK_MASK = 64'h0000_FFFF_FFFF_FFFF;

  // Shadow copy of the deck.
  logic [31:0]     dur_mem [DEPTH];
  int unsigned     tape_len;
  int unsigned     pidx;
  logic [31:0]     ctt;
  logic            lvl;
  bit              active, armed, rewinding, paused;
  longint unsigned carry, cyc_clk, last_read;
  logic            init_lvl;
  logic [7:0]      speed;
  logic [23:0]     gap;

  rsp_t            expected_q[$];
  int              fails = 0;
  int              waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  function automatic void deck_restart();
    armed     = 0;
    active    = 0;
    pidx      = 0;
    ctt       = '0;
    lvl       = init_lvl;
    rewinding = 0;
    carry     = 0;
    last_read = cyc_clk;
  endfunction

  // Rewind walks back over whole pulses that fit in the budget; leftover is carried.
  function automatic void rewind_walk(int unsigned cyc);
    longint unsigned budget;
    if (paused) return;
    if (tape_len == 0 || pidx == 0) begin
      deck_restart();
      return;
    end
    budget = 64'(cyc);
    budget = budget * speed + carry;
    while (pidx > 0) begin
      if (budget < dur_mem[pidx-1]) begin
        carry = budget;
        return;
      end
      budget -= dur_mem[pidx-1];
      pidx--;
      lvl = ~lvl;
    end
    deck_restart();
  endfunction

  function automatic void play_walk(int unsigned cyc);
    longint unsigned rem;
    rem = 64'(cyc);
    if (rewinding) begin
      rewind_walk(cyc);
      return;
    end
    if (!active || tape_len == 0 || cyc == 0 || paused) return;
    while (rem > 0 && active) begin
      if (ctt == 0) begin
        if (pidx >= tape_len) begin
          active = 0;
          break;
        end
        ctt = dur_mem[pidx];
        pidx++;
      end
      if (rem < ctt) begin
        ctt -= rem[31:0];
        break;
      end
      rem -= ctt;
      ctt = '0;
      lvl = ~lvl;
      if (pidx >= tape_len) active = 0;
    end
  endfunction

  function automatic rsp_t predict_deck(req_t r);
    rsp_t o;
    bit   full;
    full = 0;
    case (r.req_type)
      REQ_EJECT: begin
        tape_len = 0;
        deck_restart();
        lvl = 0;
      end
      REQ_APPEND: begin
        if (tape_len >= DEPTH) begin
          full = 1;
        end else begin
          dur_mem[tape_len] = (r.duration == 0) ? 32'd1 : r.duration;
          tape_len++;
        end
      end
      REQ_PLAY: begin
        if (tape_len != 0) begin
          paused = 0;
          deck_restart();
          armed = 1;
        end
      end
      REQ_STOP: begin
        active    = 0;
        armed     = 0;
        rewinding = 0;
        carry     = 0;
        ctt       = '0;
      end
      REQ_REWIND: begin
        if (tape_len == 0 || pidx == 0) begin
          deck_restart();
        end else begin
          rewinding = 1;
          carry     = 0;
          active    = 0;
          armed     = 0;
        end
      end
      REQ_PAUSE: paused = r.pause_value;
      REQ_ADVANCE: begin
        if (r.cycle_count != 0) begin
          play_walk(32'(r.cycle_count));
          cyc_clk = (cyc_clk + r.cycle_count) & CLK_MASK;
        end
      end
      default: begin
        // A read either starts an armed tape or restarts after a long idle gap.
        if (!rewinding) begin
          if (armed || (tape_len != 0 && pidx > 0 &&
              ((cyc_clk - last_read) & CLK_MASK) > gap)) begin
            pidx   = 0;
            ctt    = '0;
            lvl    = init_lvl;
            active = (tape_len != 0);
            armed  = 0;
          end
          last_read = cyc_clk;
        end
      end
    endcase
    o.tape_level  = lvl;
    o.playing     = active;
    o.armed       = armed;
    o.rewind_busy = rewinding;
    o.position    = pidx[14:0];
    o.store_full  = full;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      init_lvl = 1'b0;
      speed    = 8'd8;
      gap      = 24'd511363;
      tape_len = 0;
      cyc_clk  = 0;
      paused   = 0;
      deck_restart();
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INITIAL_LEVEL: init_lvl = cfg_data_i[0];
          CFG_REWIND_SPEED:  speed    = cfg_data_i[7:0];
          CFG_LEADER_GAP:    gap      = cfg_data_i;
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i)
        expected_q.insert(expected_q.size(), predict_deck(req_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected response", 32'(rsp_i), 32'd0);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (rsp_i.tape_level !== want.tape_level)
            report("tape_level", 32'(rsp_i.tape_level), 32'(want.tape_level));
          if (rsp_i.playing !== want.playing)
            report("playing", 32'(rsp_i.playing), 32'(want.playing));
          if (rsp_i.armed !== want.armed)
            report("armed", 32'(rsp_i.armed), 32'(want.armed));
          if (rsp_i.rewind_busy !== want.rewind_busy)
            report("rewind_busy", 32'(rsp_i.rewind_busy), 32'(want.rewind_busy));
          if (rsp_i.position !== want.position)
            report("position", 32'(rsp_i.position), 32'(want.position));
          if (rsp_i.store_full !== want.store_full)
            report("store_full", 32'(rsp_i.store_full), 32'(want.store_full));
        end
      end
    end
    waiting = expected_q.size();
  end

  // The top reads the leftover count at the end; leftovers are failures.
endmodule

[tb/sv/tb_tape_pulse_playback_engine_unit.sv]
`timescale 1ns / 1ps
module tb_tape_pulse_playback_engine_unit;
  import tppe_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        req_valid_i;
  logic        req_ready_o;
  req_t        req_i;
  logic        rsp_valid_o;
  logic        rsp_ready_i;
  rsp_t        rsp_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  int          fail_count;
  int          pending;

  // When set, both sides run back to back without idle cycles.
  bit          no_idle;
  // Number of durations appended since the last eject, used to keep tapes short.
  int unsigned tape_items;

  tape_pulse_playback_engine_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  tppe_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_i  (req_ready_o),
    .req_i        (req_i),
    .rsp_valid_i  (rsp_valid_o),
    .rsp_ready_i  (rsp_ready_i),
    .rsp_i        (rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  function automatic req_t mk(req_e kind, logic [31:0] dur, logic [15:0] cyc, logic pv);
    req_t r;
    r.req_type    = kind;
    r.duration    = dur;
    r.cycle_count = cyc;
    r.pause_value = pv;
    return r;
  endfunction

  // Presents one request after a random gap and returns at the edge that takes it.
  // Valid is only lowered when a gap follows, so it never drops and rises in one step.
  task automatic send(req_t r);
    int gap_cycles;
    gap_cycles = no_idle ? 0 : $urandom_range(0, 13);
    if (gap_cycles > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap_cycles) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    // Ready only moves just after a rising edge, so the falling edge sees it settled.
    do @(negedge clk_i); while (!req_ready_o);
    @(posedge clk_i);
    if (r.req_type == REQ_EJECT) tape_items = 0;
    else if (r.req_type == REQ_APPEND) tape_items++;
  endtask

  // Registers change only with nothing in flight; valid drops first so the last
  // request is not taken twice, and a short pause covers the block's turnaround.
  task automatic write_cfg(logic [1:0] idx, logic [23:0] data);
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well formed deck use: short tapes of short pulses, with noise in every field.
  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    pick          = $urandom_range(0, 99);
    r.duration    = $urandom_range(1, 40);
    r.cycle_count = 16'($urandom_range(1, 60));
    r.pause_value = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: r.duration = '0;
      1: r.duration = $urandom();
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: r.cycle_count = '0;
      1: r.cycle_count = 16'($urandom());
      default: ;
    endcase
    if (pick < 4 || (tape_items > 40 && pick < 30)) r.req_type = REQ_EJECT;
    else if (pick < 30) r.req_type = REQ_APPEND;
    else if (pick < 36) r.req_type = REQ_PLAY;
    else if (pick < 40) r.req_type = REQ_STOP;
    else if (pick < 48) r.req_type = REQ_REWIND;
    else if (pick < 53) r.req_type = REQ_PAUSE;
    else if (pick < 82) r.req_type = REQ_ADVANCE;
    else r.req_type = REQ_READ;
    return r;
  endfunction

  // Response side: stalls are drawn per response and may start before valid rises.
  initial begin
    int stall;
    rsp_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        rsp_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ready_i <= 1'b1;
      do @(negedge clk_i); while (!rsp_valid_o);
      @(posedge clk_i);
    end
  end

  initial begin
    logic [7:0]  spd;
    logic [23:0] gp;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    no_idle     = 1'b0;
    tape_items  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty deck requests, zero and widest durations, arming,
    // play across pulses, pause, rewind to the start and a read soon after.
    send(mk(REQ_READ, '0, '0, 1'b0));
    send(mk(REQ_ADVANCE, '1, 16'd0, 1'b0));
    send(mk(REQ_PLAY, '0, '0, 1'b0));
    send(mk(REQ_REWIND, '0, '0, 1'b0));
    send(mk(REQ_STOP, '0, '0, 1'b0));
    send(mk(REQ_APPEND, 32'd0, '0, 1'b0));
    send(mk(REQ_APPEND, 32'd7, '0, 1'b0));
    send(mk(REQ_APPEND, 32'd3, '0, 1'b0));
    send(mk(REQ_APPEND, 32'hFFFF_FFFF, '1, 1'b1));
    send(mk(REQ_PLAY, '0, '0, 1'b0));
    send(mk(REQ_ADVANCE, '0, 16'd10, 1'b0));
    send(mk(REQ_READ, '0, '0, 1'b0));
    send(mk(REQ_ADVANCE, '0, 16'd1, 1'b0));
    send(mk(REQ_ADVANCE, '0, 16'd12, 1'b0));
    send(mk(REQ_PAUSE, '0, '0, 1'b1));
    send(mk(REQ_ADVANCE, '0, 16'd100, 1'b0));
    send(mk(REQ_PAUSE, '0, '0, 1'b0));
    send(mk(REQ_REWIND, '0, '0, 1'b0));
    send(mk(REQ_READ, '0, '0, 1'b0));
    send(mk(REQ_ADVANCE, '0, 16'd1, 1'b0));
    send(mk(REQ_ADVANCE, '0, 16'hFFFF, 1'b0));
    send(mk(REQ_READ, '0, '0, 1'b0));
    send(mk(REQ_ADVANCE, '0, 16'hFFFF, 1'b0));
    send(mk(REQ_READ, '0, '0, 1'b0));
    send(mk(REQ_EJECT, '0, '0, 1'b0));

    // Deck controls right after an eject, with no tape loaded.
    send(mk(REQ_PLAY, '0, '0, 1'b0));
    send(mk(REQ_READ, '0, '0, 1'b0));
    send(mk(REQ_ADVANCE, '0, 16'd3, 1'b0));
    send(mk(REQ_REWIND, '0, '0, 1'b0));
    send(mk(REQ_ADVANCE, '0, 16'd2, 1'b0));
    send(mk(REQ_STOP, '0, '0, 1'b0));
    send(mk(REQ_EJECT, '0, '0, 1'b0));

    // Random phases, each under its own register setting; the first keeps reset values.
    for (int ph = 0; ph < 6; ph++) begin
      spd = 8'($urandom_range(1, 255));
      gp  = 24'($urandom_range(0, 200));
      case (ph)
        1: begin
          write_cfg(CFG_INITIAL_LEVEL, 24'd1);
          write_cfg(CFG_REWIND_SPEED, 24'd1);
          write_cfg(CFG_LEADER_GAP, 24'd0);
        end
        2: begin
          write_cfg(CFG_INITIAL_LEVEL, 24'd0);
          write_cfg(CFG_REWIND_SPEED, 24'd255);
          write_cfg(CFG_LEADER_GAP, 24'hFF_FFFF);
        end
        3: begin
          write_cfg(CFG_INITIAL_LEVEL, 24'd1);
          write_cfg(CFG_REWIND_SPEED, {16'd0, spd});
          write_cfg(CFG_LEADER_GAP, 24'd20);
        end
        4: begin
          write_cfg(CFG_REWIND_SPEED, 24'd3);
          write_cfg(CFG_LEADER_GAP, gp);
        end
        5: begin
          write_cfg(CFG_INITIAL_LEVEL, 24'd0);
          write_cfg(CFG_REWIND_SPEED, 24'd8);
          write_cfg(CFG_LEADER_GAP, 24'd511363);
        end
        default: ;
      endcase
      for (int i = 0; i < 200; i++) begin
        // Stretches without idling on either side, about one item in six.
        if (i % 40 == 0) no_idle = ($urandom_range(0, 5) == 0);
        send(random_req());
      end
    end
    req_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule

[sim.f]
rtl/core/tppe_pkg.sv
rtl/core/tape_pulse_playback_engine_unit.sv
tb/sv/tppe_checker.sv
tb/sv/tb_tape_pulse_playback_engine_unit.sv
